// File: hdl/cqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqe_pkg
// Shared types and codes for the circular queue engine.
// ----------------------------------------------------------------------------
package cqe_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;
	localparam int FUNC_W    = 3;
	localparam int POS_W     = 5;
	localparam int STAT_W    = 3;

	// operation codes; 6 and 7 are no-ops
	localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_PEEK    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CHANGE  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SEARCH  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DISPLAY = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_POS   = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [WORD_W-1:0] value;
		logic [POS_W-1:0]         position;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [WORD_W-1:0] data;
		logic [POS_W-1:0]         found_position;
		logic                     full_res;
		logic                     empty_res;
		logic                     last;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RESP,
		S_WALK
	} seq_state_t;

endpackage

// File: hdl/cqe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cqe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/circular_queue_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_engine_top
// Circular FIFO of signed 32-bit words with insert, delete, peek, change,
// search and display operations; storage in one registered-read RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - cmd channel (cmd_valid / cmd_stall / cmd) carries one operation per item.
//  - rsp channel (rsp_valid / rsp_stall / rsp) returns the results; the final
//    result of an item has last set. Display returns one result per entry,
//    oldest first; every other operation returns exactly one.
//  - Insert, change, no-op codes and every error case finish in the accept
//    cycle: the result is written to the output register, and a new item can be
//    taken every cycle while the receiver does not stall.
//  - Delete and peek need one RAM read and pass through S_RESP; no new item is taken until the result is loaded.
//  - Search and display walk the RAM one entry per cycle from the head, display
//    pausing while the receiver stalls.
//    The RAM read port sets this rate.
//  - Items are executed one at a time; no two RAM accesses to one entry can
//    overlap, so no forwarding is needed.
//  - Reset clears head, tail and occupancy; the RAM is not cleared, since
//    only occupied slots are ever read.
//  - A stalled receiver holds the output register; a display walk pauses with it,
//    and cmd_stall stays high until the register can take a new result.
// ----------------------------------------------------------------------------
module circular_queue_engine_top import cqe_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
	localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(DEPTH);

	function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	// state and control registers
	seq_state_t        state_q, state_d;
	logic [PTR_W-1:0]  head_q, head_d;
	logic [PTR_W-1:0]  tail_q, tail_d;
	logic [CNT_W-1:0]  occ_q, occ_d;
	logic [PTR_W-1:0]  walk_ptr_q, walk_ptr_d;
	logic [PTR_W-1:0]  idx_q, idx_d;
	logic              disp_q, disp_d;
	logic [WORD_W-1:0] key_q, key_d;
	rsp_t              rsp_q, rsp_d;
	logic              rsp_valid_q;
	logic              rsp_load;

	// RAM port
	logic              rd_en, wr_en;
	logic [PTR_W-1:0]  rd_addr, wr_addr;
	logic [WORD_W-1:0] wr_data, rd_data;

	// helpers
	logic              out_free, accept, occ_empty, occ_full, pos_ok;
	logic              idx_last, hit;
	logic [PTR_W:0]    chg_sum;
	logic [PTR_W-1:0]  chg_addr, peek_addr;
	logic [CNT_W-1:0]  idx_p1;

	cqe_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE) || !out_free;
	assign accept    = cmd_valid && !cmd_stall;
	assign occ_empty = (occ_q == '0);
	assign occ_full  = (occ_q == FULL_CNT);

	// change target: head + position - 1, wrapped
	assign pos_ok    = (CMP_W'(cmd.position) != '0) &&
	                   (CMP_W'(cmd.position) <= CMP_W'(occ_q));
	assign chg_sum   = {1'b0, head_q} + (PTR_W + 1)'(cmd.position - POS_W'(1));
	assign chg_addr  = (chg_sum >= DEPTH_X) ? PTR_W'(chg_sum - DEPTH_X)
	                                        : chg_sum[PTR_W-1:0];
	// newest entry sits one slot behind the tail
	assign peek_addr = (tail_q == '0) ? LAST_SLOT : tail_q - 1'b1;

	assign idx_p1    = CNT_W'(idx_q) + CNT_W'(1);
	assign idx_last  = (idx_p1 == occ_q);
	assign hit       = (rd_data == key_q);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		occ_d      = occ_q;
		walk_ptr_d = walk_ptr_q;
		idx_d      = idx_q;
		disp_d     = disp_q;
		key_d      = key_q;
		rd_en      = 1'b0;
		rd_addr    = head_q;
		wr_en      = 1'b0;
		wr_addr    = tail_q;
		wr_data    = cmd.value;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		rsp_d.status = STAT_OK;
		rsp_d.last   = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd.func)
						FN_INSERT: begin
							rsp_load = 1'b1;
							if (occ_full) begin
								rsp_d.status = STAT_OVERFLOW;
							end else begin
								wr_en  = 1'b1;
								tail_d = slot_inc(tail_q);
								occ_d  = occ_q + 1'b1;
							end
						end
						FN_DELETE: begin
							if (occ_empty) begin
								rsp_load     = 1'b1;
								rsp_d.status = STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q;
								head_d  = slot_inc(head_q);
								occ_d   = occ_q - 1'b1;
								state_d = S_RESP;
							end
						end
						FN_PEEK: begin
							if (occ_empty) begin
								rsp_load     = 1'b1;
								rsp_d.status = STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = peek_addr;
								state_d = S_RESP;
							end
						end
						FN_CHANGE: begin
							rsp_load = 1'b1;
							if (!pos_ok) begin
								rsp_d.status = STAT_BAD_POS;
							end else begin
								wr_en   = 1'b1;
								wr_addr = chg_addr;
							end
						end
						FN_SEARCH, FN_DISPLAY: begin
							if (occ_empty) begin
								rsp_load     = 1'b1;
								rsp_d.status = STAT_EMPTY;
							end else begin
								rd_en      = 1'b1;
								rd_addr    = head_q;
								walk_ptr_d = slot_inc(head_q);
								idx_d      = '0;
								key_d      = cmd.value;
								disp_d     = (cmd.func == FN_DISPLAY);
								state_d    = S_WALK;
							end
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			S_RESP: begin
				if (out_free) begin
					rsp_load   = 1'b1;
					rsp_d.data = rd_data;
					state_d    = S_IDLE;
				end
			end
			S_WALK: begin
				// rd_data holds entry idx_q; fetch the next one as it is consumed
				if (disp_q) begin
					if (out_free) begin
						rsp_load   = 1'b1;
						rsp_d.data = rd_data;
						rsp_d.last = idx_last;
						if (idx_last) begin
							state_d = S_IDLE;
						end else begin
							rd_en      = 1'b1;
							rd_addr    = walk_ptr_q;
							walk_ptr_d = slot_inc(walk_ptr_q);
							idx_d      = idx_q + 1'b1;
						end
					end
				end else if (hit) begin
					if (out_free) begin
						rsp_load             = 1'b1;
						rsp_d.found_position = POS_W'(idx_p1);
						state_d              = S_IDLE;
					end
				end else if (idx_last) begin
					if (out_free) begin
						rsp_load     = 1'b1;
						rsp_d.status = STAT_NOT_FOUND;
						state_d      = S_IDLE;
					end
				end else begin
					rd_en      = 1'b1;
					rd_addr    = walk_ptr_q;
					walk_ptr_d = slot_inc(walk_ptr_q);
					idx_d      = idx_q + 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// flags reflect the queue after the operation
		rsp_d.full_res  = (occ_d == FULL_CNT);
		rsp_d.empty_res = (occ_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			occ_q   <= occ_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// walk context and result payload
	always_ff @(posedge clk) begin
		walk_ptr_q <= walk_ptr_d;
		idx_q      <= idx_d;
		disp_q     <= disp_d;
		key_q      <= key_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	logic [PTR_W:0]   ptr_sum;
	logic [PTR_W-1:0] ptr_wrap;

	assign ptr_sum  = {1'b0, head_q} + (PTR_W + 1)'(occ_q);
	assign ptr_wrap = (ptr_sum >= DEPTH_X) ? PTR_W'(ptr_sum - DEPTH_X)
	                                       : ptr_sum[PTR_W-1:0];

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FULL_CNT)
		else $error("occupancy exceeds depth");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_wrap == tail_q)
		else $error("head + occupancy does not land on tail");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (CNT_W'(idx_q) < occ_q))
		else $error("walk index beyond occupancy");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.func == FN_DELETE) && !occ_empty)
		|=> (occ_q == $past(occ_q) - 1'b1))
		else $error("delete did not reduce occupancy");

endmodule
